// ----- src/positional_list_stack_macros.svh -----
`ifndef POSITIONAL_LIST_STACK_MACROS_SVH
`define POSITIONAL_LIST_STACK_MACROS_SVH

// same-cycle check, clocked on clock and held off during reset
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle check, clocked on clock and held off during reset
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/pls_pkg.sv -----
package pls_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int POS_W   = 5;
   localparam int CNT_FW  = 5;
   localparam int VAL_W   = 32;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int EXT_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [2:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_PEEK   = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_REMOVE = 3'd4,
      CMD_READ   = 3'd5,
      CMD_CLEAR  = 3'd6
   } command_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_BAD  = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef struct packed {
      command_type              command;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [VAL_W-1:0]  data;
      logic [CNT_FW-1:0]        count;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_DONE = 2'd2
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
   } pls_cmd_type;

endpackage

// ----- src/positional_list_stack.sv -----
// the request is registered, runs in S_EXEC, and the result is registered and offered in S_DONE
// a new command is taken only while idle or when the previous result is taken
// each command runs in the execute state; the cell chain shifts the entries from the addressed one on together
// reset clears the controller and the entry count; entry contents are not reset
// a request waiting during a result transfer is taken in that same cycle
module positional_list_stack
   import pls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   pls_cmd_type cmd;

   pls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   pls_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ----- src/pls_ctrl.sv -----
module pls_ctrl
   import pls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pls_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // result leaves; a waiting request goes straight in
            if (!rsp_stall) state_in = req_valid ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.exec  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      // no request is taken while reset is held
      if (reset) req_stall = 1'b1;
      cmd.load = req_valid && !req_stall;
   end

endmodule

// ----- src/pls_datapath.sv -----
`include "positional_list_stack_macros.svh"

module pls_datapath
   import pls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  pls_cmd_type cmd,
   input  req_type     req_data,
   output rsp_type     rsp_data
);

   logic [DATA_WIDTH-1:0] cells_ff [DEPTH];
   logic [DATA_WIDTH-1:0] cells_in [DEPTH];
   logic [DATA_WIDTH-1:0] shift_up [DEPTH];
   logic [DATA_WIDTH-1:0] shift_dn [DEPTH];

   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [EXT_W-1:0]      pos_ext, cnt_ext;
   logic [POS_W-1:0]      pos_m1;
   logic [IDX_W-1:0]      idx;
   logic [DATA_WIDTH-1:0] rd_data, new_val;
   logic                  is_full, pos_ins_ok, pos_rd_ok, do_ins, do_rem;

   always_comb begin
      pos_ext    = EXT_W'(req_ff.position);
      cnt_ext    = EXT_W'(count_ff);
      pos_m1     = req_ff.position - 1'b1;
      idx        = (req_ff.command inside {CMD_PUSH, CMD_POP, CMD_PEEK}) ? '0
                                                                      : IDX_W'(pos_m1);
      rd_data    = cells_ff[idx];
      new_val    = DATA_WIDTH'($unsigned(req_ff.value));
      is_full    = (count_ff == CNT_W'(DEPTH));
      pos_ins_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1);
      pos_rd_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
   end

   always_comb begin
      do_ins        = 1'b0;
      do_rem        = 1'b0;
      count_in      = count_ff;
      rsp_in.status = STAT_OK;
      rsp_in.data   = '0;
      unique case (req_ff.command)
         CMD_PUSH: begin
            if (is_full) begin
               rsp_in.status = STAT_FULL;
            end else begin
               do_ins   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP: begin
            if (count_ff == '0) begin
               rsp_in.status = STAT_BAD;
            end else begin
               do_rem      = 1'b1;
               count_in    = count_ff - 1'b1;
               rsp_in.data = VAL_W'(rd_data);
            end
         end
         CMD_PEEK: begin
            if (count_ff == '0) rsp_in.status = STAT_BAD;
            else rsp_in.data = VAL_W'(rd_data);
         end
         CMD_INSERT: begin
            // position is checked before fullness
            if (!pos_ins_ok) begin
               rsp_in.status = STAT_BAD;
            end else if (is_full) begin
               rsp_in.status = STAT_FULL;
            end else begin
               do_ins   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (!pos_rd_ok) begin
               rsp_in.status = STAT_BAD;
            end else begin
               do_rem      = 1'b1;
               count_in    = count_ff - 1'b1;
               rsp_in.data = VAL_W'(rd_data);
            end
         end
         CMD_READ: begin
            if (!pos_rd_ok) rsp_in.status = STAT_BAD;
            else rsp_in.data = VAL_W'(rd_data);
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            rsp_in.status = STAT_BAD;
         end
      endcase
      rsp_in.count = CNT_FW'(count_in);
   end

   // each cell takes its own value, its upper neighbor's, its lower neighbor's or the new value
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         assign shift_up[i] = new_val;
      end else begin : g_mid
         assign shift_up[i] = cells_ff[i-1];
      end
      if (i == DEPTH - 1) begin : g_bot
         assign shift_dn[i] = cells_ff[i];
      end else begin : g_rest
         assign shift_dn[i] = cells_ff[i+1];
      end
      assign cells_in[i] = (IDX_W'(i) < idx)  ? cells_ff[i] :
                           !do_ins            ? shift_dn[i] :
                           (IDX_W'(i) == idx) ? new_val     : shift_up[i];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.exec) rsp_ff <= rsp_in;
      if (cmd.exec && (do_ins || do_rem)) cells_ff <= cells_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign rsp_data = rsp_ff;

   `PLS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "entry count above depth")
   `PLS_ASSERT_NEXT(a_push_grows, cmd.exec && req_ff.command == CMD_PUSH && !is_full, count_ff == $past(count_ff) + 1'b1, "push did not grow the list")
   `PLS_ASSERT_NEXT(a_clear_empties, cmd.exec && req_ff.command == CMD_CLEAR, count_ff == '0 && rsp_ff.count == '0, "clear left entries")

endmodule

// ----- bench/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pls_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int MAX_WAIT      = 18;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_BLOCKS = 30;
   localparam int BLOCK_ITEMS   = 61;
   localparam int PRESSURE_BLK  = 7;
   localparam int NUM_ROWS      = 21;

   // code seven is not a member of the command enum
   localparam command_type CMD_UNUSED = command_type'(3'd7);

   typedef struct packed {
      command_type cmd;
      logic [4:0]  pos;
      logic [31:0] val;
      logic [4:0]  times;
      logic        typed;
      status_type  st;
      logic [31:0] dat;
      logic [4:0]  cnt;
   } row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // stack contents as the block should hold them, index 0 is the top
   logic [DATA_WIDTH-1:0] stack_words [DEPTH];
   int                    stack_len;
   rsp_type               expected_rsp [$];

   int  req_max_wait = MAX_WAIT;
   int  rsp_max_wait = MAX_WAIT;
   bit  hold_results = 1'b0;
   int  bad_results  = 0;
   int  results_seen = 0;
   int  commands_run = 0;
   int  full_rejects = 0;
   int  pos_rejects  = 0;
   int  full_reached = 0;
   int  idle_cycles  = 0;

   row_type directed_rows [NUM_ROWS] = '{
      '{CMD_POP,    5'd0,  32'h0,        5'd1,  1'b1, STAT_BAD,  32'h0,        5'd0},
      '{CMD_PEEK,   5'd0,  32'h0,        5'd1,  1'b1, STAT_BAD,  32'h0,        5'd0},
      '{CMD_READ,   5'd1,  32'h0,        5'd1,  1'b1, STAT_BAD,  32'h0,        5'd0},
      '{CMD_INSERT, 5'd0,  32'h1,        5'd1,  1'b1, STAT_BAD,  32'h0,        5'd0},
      '{CMD_INSERT, 5'd2,  32'h1,        5'd1,  1'b1, STAT_BAD,  32'h0,        5'd0},
      '{CMD_UNUSED, 5'd0,  32'h0,        5'd1,  1'b1, STAT_BAD,  32'h0,        5'd0},
      '{CMD_PUSH,   5'd0,  32'h7FFFFFFF, 5'd1,  1'b1, STAT_OK,   32'h0,        5'd1},
      '{CMD_INSERT, 5'd2,  32'h80000000, 5'd1,  1'b1, STAT_OK,   32'h0,        5'd2},
      '{CMD_READ,   5'd2,  32'h0,        5'd1,  1'b1, STAT_OK,   32'h80000000, 5'd2},
      '{CMD_REMOVE, 5'd3,  32'h0,        5'd1,  1'b1, STAT_BAD,  32'h0,        5'd2},
      '{CMD_PEEK,   5'd0,  32'h0,        5'd1,  1'b1, STAT_OK,   32'h7FFFFFFF, 5'd2},
      '{CMD_INSERT, 5'd1,  32'hFFFFFFFF, 5'd1,  1'b0, STAT_OK,   32'h0,        5'd0},
      '{CMD_REMOVE, 5'd2,  32'h0,        5'd1,  1'b0, STAT_OK,   32'h0,        5'd0},
      '{CMD_POP,    5'd0,  32'h0,        5'd1,  1'b0, STAT_OK,   32'h0,        5'd0},
      '{CMD_PUSH,   5'd0,  32'h0,        5'd15, 1'b0, STAT_OK,   32'h0,        5'd0},
      '{CMD_PUSH,   5'd0,  32'h1234,     5'd1,  1'b1, STAT_FULL, 32'h0,        5'd16},
      '{CMD_INSERT, 5'd17, 32'h5678,     5'd1,  1'b1, STAT_FULL, 32'h0,        5'd16},
      '{CMD_INSERT, 5'd18, 32'h5678,     5'd1,  1'b1, STAT_BAD,  32'h0,        5'd16},
      '{CMD_REMOVE, 5'd16, 32'h0,        5'd1,  1'b0, STAT_OK,   32'h0,        5'd0},
      '{CMD_READ,   5'd0,  32'h0,        5'd1,  1'b1, STAT_BAD,  32'h0,        5'd15},
      '{CMD_CLEAR,  5'd31, 32'hFFFFFFFF, 5'd1,  1'b1, STAT_OK,   32'h0,        5'd0}
   };

   positional_list_stack uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // applies one command to the stack copy and returns the result it gives
   function automatic rsp_type execute_command(input req_type cmd_in);
      rsp_type res;
      int      idx;
      res.status = STAT_OK;
      res.data   = '0;
      idx        = int'(cmd_in.position) - 1;
      case (cmd_in.command)
         CMD_PUSH, CMD_INSERT: begin
            if (cmd_in.command == CMD_PUSH) idx = 0;
            if (idx < 0 || idx > stack_len) begin
               res.status = STAT_BAD;
            end else if (stack_len >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               for (int i = stack_len; i > idx; i--) stack_words[i] = stack_words[i-1];
               stack_words[idx] = cmd_in.value;
               stack_len++;
               if (stack_len == DEPTH) full_reached++;
            end
         end
         CMD_POP, CMD_PEEK, CMD_REMOVE, CMD_READ: begin
            if (cmd_in.command == CMD_POP || cmd_in.command == CMD_PEEK) idx = 0;
            if (idx < 0 || idx >= stack_len) begin
               res.status = STAT_BAD;
            end else begin
               res.data = stack_words[idx];
               if (cmd_in.command == CMD_POP || cmd_in.command == CMD_REMOVE) begin
                  for (int i = idx; i + 1 < stack_len; i++) stack_words[i] = stack_words[i+1];
                  stack_len--;
               end
            end
         end
         CMD_CLEAR: begin
            stack_len = 0;
         end
         default: begin
            res.status = STAT_BAD;
         end
      endcase
      if (res.status == STAT_FULL) full_rejects++;
      if (res.status == STAT_BAD) pos_rejects++;
      res.count = stack_len[CNT_FW-1:0];
      return res;
   endfunction

   function automatic req_type random_command(input bit grow);
      req_type cmd_out;
      int      pick;
      int      adds;
      int      share;
      pick  = $urandom_range(0, 99);
      adds  = grow ? 56 : 20;
      share = (96 - adds) / 4;
      if (pick < adds / 2)            cmd_out.command = CMD_PUSH;
      else if (pick < adds)           cmd_out.command = CMD_INSERT;
      else if (pick < adds + share)   cmd_out.command = CMD_POP;
      else if (pick < adds + 2*share) cmd_out.command = CMD_REMOVE;
      else if (pick < adds + 3*share) cmd_out.command = CMD_READ;
      else if (pick < 96)             cmd_out.command = CMD_PEEK;
      else if (pick < 98)             cmd_out.command = CMD_CLEAR;
      else                            cmd_out.command = CMD_UNUSED;

      // mostly legal positions, with some anywhere in the field
      cmd_out.position = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 99) >= 12) begin
         if (cmd_out.command == CMD_INSERT)
            cmd_out.position = 5'($urandom_range(1, stack_len + 1));
         else if (stack_len > 0 &&
                  (cmd_out.command == CMD_REMOVE || cmd_out.command == CMD_READ))
            cmd_out.position = 5'($urandom_range(1, stack_len));
      end

      case ($urandom_range(0, 19))
         0:       cmd_out.value = 32'h0;
         1:       cmd_out.value = 32'h7FFFFFFF;
         2:       cmd_out.value = 32'h80000000;
         3:       cmd_out.value = 32'hFFFFFFFF;
         default: cmd_out.value = $urandom;
      endcase
      return cmd_out;
   endfunction

   // offers one command and records its result once the transfer happens
   task automatic run_command(input req_type cmd_in, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      gap = $urandom_range(0, req_max_wait);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = execute_command(cmd_in);
      if (typed) predicted = typed_rsp;
      expected_rsp.push_back(predicted);
      commands_run++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // result side: draws a wait per result, or holds off for a long stretch on request
   initial begin : result_side
      int      wait_left;
      rsp_type want;
      wait_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
               $error("result transfer with nothing expected: %p", rsp_data);
               bad_results++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_data.status);
                  bad_results++;
               end
               if (rsp_data.data !== want.data) begin
                  $error("data expected %h got %h", want.data, rsp_data.data);
                  bad_results++;
               end
               if (rsp_data.count !== want.count) begin
                  $error("count expected %0d got %0d", want.count, rsp_data.count);
                  bad_results++;
               end
            end
            wait_left = $urandom_range(0, rsp_max_wait);
         end
         if (hold_results) begin
            hold_results = 1'b0;
            wait_left    = HOLD_CYCLES;
         end
         if (wait_left > 0) begin
            rsp_stall <= 1'b1;
            wait_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      req_type stim;
      rsp_type typed_rsp;
      bit      grow;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      stack_len = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         for (int k = 0; k < directed_rows[i].times; k++) begin
            stim.command     = directed_rows[i].cmd;
            stim.position    = directed_rows[i].pos;
            stim.value       = directed_rows[i].val + k;
            typed_rsp.status = directed_rows[i].st;
            typed_rsp.data   = directed_rows[i].dat;
            typed_rsp.count  = directed_rows[i].cnt;
            run_command(stim, directed_rows[i].typed, typed_rsp);
         end
      end
      drain_results();

      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         grow = ($urandom_range(0, 1) == 1);
         // rotate idling: both sides, neither, sender only, receiver only
         req_max_wait = (blk % 4 == 0 || blk % 4 == 2) ? MAX_WAIT : 0;
         rsp_max_wait = (blk % 4 == 0 || blk % 4 == 3) ? MAX_WAIT : 0;
         if (blk == PRESSURE_BLK) begin
            req_max_wait = 0;
            hold_results = 1'b1;
         end
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            stim = random_command(grow);
            run_command(stim, 1'b0, '0);
         end
         if (blk % 6 == 5) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d commands, checked %0d results; stack filled %0d times",
               commands_run, results_seen, full_reached);
      $display("rejects seen: %0d on a full stack, %0d on bad position or empty",
               full_rejects, pos_rejects);
      if (bad_results == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/pls_pkg.sv
src/pls_ctrl.sv
src/pls_datapath.sv
src/positional_list_stack.sv
bench/tb.sv
